/* hdl/tfc_pkg.sv */
// Shared constants, types and codes for the TCP flow classifier.
// No dependencies; tfc_result_if and the classifier core import this package.

package tfc_pkg;

    // Flow table geometry
    localparam int FLOW_ENTRIES  = 64;
    localparam int FLOW_ID_BITS  = $clog2(FLOW_ENTRIES);
    localparam int FLOW_CNT_BITS = $clog2(FLOW_ENTRIES + 1);
    localparam int INDEX_BITS    = 16;

    // Stored key: ordered address pair then ordered port pair
    localparam int KEY_BITS = 96;

    // Frame layout, byte offsets from the start of the Ethernet frame
    localparam logic [INDEX_BITS-1:0] IHL_OFFSET   = INDEX_BITS'(14);
    localparam logic [INDEX_BITS-1:0] PROTO_OFFSET = INDEX_BITS'(23);
    localparam logic [INDEX_BITS-1:0] SRC_OFFSET   = INDEX_BITS'(26);
    localparam logic [INDEX_BITS-1:0] DST_OFFSET   = INDEX_BITS'(30);
    localparam logic [INDEX_BITS-1:0] DST_END      = INDEX_BITS'(34);
    localparam logic [INDEX_BITS-1:0] MIN_LAST_IDX = INDEX_BITS'(29);
    localparam logic [3:0]            IHL_MASK     = 4'hF;
    localparam logic [7:0]            TCP_PROTO    = 8'd9 - 8'd3;

    // Configuration port
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 32;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FILTER_ENABLE = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FILTER_ADDR   = 1'b1;

    typedef enum logic [1:0] {
        CLS_SHORT    = 2'd0,
        CLS_FILTERED = 2'd1,
        CLS_NON_TCP  = 2'd2,
        CLS_TCP      = 2'd3
    } class_t;

    typedef struct packed {
        class_t                  frame_class;
        logic [FLOW_ID_BITS-1:0] flow_id;
        logic                    new_flow;
        logic                    table_full;
    } result_t;

    typedef enum logic [1:0] {
        ST_CAPTURE,
        ST_CLASSIFY,
        ST_SEARCH,
        ST_EMIT
    } state_t;

endpackage

/* hdl/tfc_byte_if.sv */
// Byte channel into the classifier: valid/ready plus one frame byte.
// Depends on nothing beyond the language.

interface tfc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

/* hdl/tfc_result_if.sv */
// Result channel out of the classifier: valid/ready plus one class word.
// Depends on tfc_pkg for the class type and flow id width.

interface tfc_result_if import tfc_pkg::*; ;
    logic                    valid;
    logic                    ready;
    class_t                  frame_class;
    logic [FLOW_ID_BITS-1:0] flow_id;
    logic                    new_flow;
    logic                    table_full;

    modport source (output valid, output frame_class, output flow_id,
                    output new_flow, output table_full, input ready);
    modport sink   (input valid, input frame_class, input flow_id,
                    input new_flow, input table_full, output ready);
endinterface

/* hdl/tfc_ram.sv */
// Generic single-clock RAM, one write port and one read port, registered read.
// No dependencies.

module tfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, and read through a register
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hdl/tcp_flow_classifier_core.sv */
// TCP flow classifier: frame byte capture, classification and flow table lookup.
// Bytes are taken one per cycle while capturing. After the last byte: a classify state, a flow RAM scan of
// one entry a cycle (skipped for a frame not classed TCP or an empty table), then an emit state that
// loads the result register once the output is free. Input is held off from the last byte until the
// result word is loaded, and so longer while an earlier word still waits.
// Reset clears control, frame registers and the flow count; the flow RAM is not cleared.

module tcp_flow_classifier_core import tfc_pkg::*; (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    tfc_byte_if.sink                  byte_in,
    tfc_result_if.source              result_out
);

    state_t                   state_reg, state_next;
    logic [INDEX_BITS-1:0]    byte_index_reg, byte_index_next;
    logic [3:0]               hlen_reg, hlen_next;
    logic [7:0]               proto_reg, proto_next;
    logic [31:0]              saddr_reg, saddr_next;
    logic [31:0]              daddr_reg, daddr_next;
    logic [31:0]              ports_reg, ports_next;
    logic [FLOW_CNT_BITS-1:0] flows_reg, flows_next;
    logic [KEY_BITS-1:0]      key_reg, key_next;
    logic [FLOW_ID_BITS-1:0]  scan_reg, scan_next;
    result_t                  res_reg, res_next;
    result_t                  out_reg, out_next;
    logic                     out_valid_reg, out_valid_next;
    logic                     filter_en_reg;
    logic [31:0]              filter_addr_reg;

    logic                     accept;
    logic [3:0]               hlen_eff;
    logic [INDEX_BITS-1:0]    port_off;
    logic [INDEX_BITS-1:0]    port_diff;
    logic [INDEX_BITS-1:0]    src_diff;
    logic [INDEX_BITS-1:0]    dst_diff;
    logic                     src_first;
    logic [KEY_BITS-1:0]      key_comb;
    class_t                   cls_comb;
    logic                     hit;
    logic                     scan_done;
    logic                     room;
    logic                     out_free;

    logic                     ram_we;
    logic [FLOW_ID_BITS-1:0]  ram_waddr;
    logic [KEY_BITS-1:0]      ram_wdata;
    logic [FLOW_ID_BITS-1:0]  ram_raddr;
    logic [KEY_BITS-1:0]      ram_rdata;

    function automatic logic [31:0] put_byte(input logic [31:0] w,
                                             input logic [1:0]  k,
                                             input logic [7:0]  b);
        logic [31:0] r;
        r = w;
        unique case (k)
            2'd0: r[31:24] = b;
            2'd1: r[23:16] = b;
            2'd2: r[15:8]  = b;
            2'd3: r[7:0]   = b;
        endcase
        return r;
    endfunction

    // Flow key store: {ordered addresses, ordered ports}
    tfc_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (FLOW_ENTRIES)
    ) u_flow_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign accept          = byte_in.valid && byte_in.ready;
    assign byte_in.ready   = (state_reg == ST_CAPTURE);
    assign out_free        = !out_valid_reg || result_out.ready;

    // Header field positions for the byte now on the channel
    assign hlen_eff  = (byte_index_reg == IHL_OFFSET) ? (byte_in.data_byte[3:0] & IHL_MASK)
                                                      : hlen_reg;
    assign port_off  = IHL_OFFSET + INDEX_BITS'({hlen_eff, 2'b00});
    assign port_diff = byte_index_reg - port_off;
    assign src_diff  = byte_index_reg - SRC_OFFSET;
    assign dst_diff  = byte_index_reg - DST_OFFSET;

    // Classify from the captured header
    always_comb
    begin
        priority if (byte_index_reg < MIN_LAST_IDX)
            cls_comb = CLS_SHORT;
        else if (filter_en_reg && saddr_reg != filter_addr_reg
                 && daddr_reg != filter_addr_reg)
            cls_comb = CLS_FILTERED;
        else if (proto_reg != TCP_PROTO)
            cls_comb = CLS_NON_TCP;
        else
            cls_comb = CLS_TCP;
    end

    // Order the endpoints, larger (address, port) first
    assign src_first = {saddr_reg, ports_reg[31:16]} >= {daddr_reg, ports_reg[15:0]};
    assign key_comb  = src_first
                     ? {saddr_reg, daddr_reg, ports_reg[31:16], ports_reg[15:0]}
                     : {daddr_reg, saddr_reg, ports_reg[15:0], ports_reg[31:16]};

    assign hit       = (ram_rdata == key_reg);
    assign scan_done = ((FLOW_CNT_BITS'(scan_reg) + FLOW_CNT_BITS'(1)) == flows_reg);
    assign room      = (flows_reg < FLOW_CNT_BITS'(FLOW_ENTRIES));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CAPTURE:
            begin
                if (accept && byte_in.last_byte)
                    state_next = ST_CLASSIFY;
            end
            ST_CLASSIFY:
            begin
                if (cls_comb == CLS_TCP && flows_reg != '0)
                    state_next = ST_SEARCH;
                else
                    state_next = ST_EMIT;
            end
            ST_SEARCH:
            begin
                if (hit || scan_done)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                    state_next = ST_CAPTURE;
            end
            default: state_next = ST_CAPTURE;
        endcase
    end

    // Datapath and RAM control
    always_comb
    begin
        byte_index_next = byte_index_reg;
        hlen_next       = hlen_reg;
        proto_next      = proto_reg;
        saddr_next      = saddr_reg;
        daddr_next      = daddr_reg;
        ports_next      = ports_reg;
        flows_next      = flows_reg;
        key_next        = key_reg;
        scan_next       = scan_reg;
        res_next        = res_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !result_out.ready;
        ram_we          = 1'b0;
        ram_waddr       = flows_reg[FLOW_ID_BITS-1:0];
        ram_wdata       = key_reg;
        ram_raddr       = scan_reg;

        unique case (state_reg)
            ST_CAPTURE:
            begin
                // Capture header bytes; hold the index on the last byte
                if (accept)
                begin
                    if (byte_index_reg == IHL_OFFSET)
                        hlen_next = hlen_eff;
                    if (byte_index_reg == PROTO_OFFSET)
                        proto_next = byte_in.data_byte;
                    if (byte_index_reg >= SRC_OFFSET && byte_index_reg < DST_OFFSET)
                        saddr_next = put_byte(saddr_reg, src_diff[1:0], byte_in.data_byte);
                    if (byte_index_reg >= DST_OFFSET && byte_index_reg < DST_END)
                        daddr_next = put_byte(daddr_reg, dst_diff[1:0], byte_in.data_byte);
                    if (byte_index_reg >= port_off && port_diff < INDEX_BITS'(4))
                        ports_next = put_byte(ports_reg, port_diff[1:0], byte_in.data_byte);
                    if (!byte_in.last_byte && byte_index_reg != '1)
                        byte_index_next = byte_index_reg + INDEX_BITS'(1);
                end
            end
            ST_CLASSIFY:
            begin
                res_next.frame_class = cls_comb;
                res_next.flow_id     = '0;
                res_next.new_flow    = 1'b0;
                res_next.table_full  = 1'b0;
                key_next             = key_comb;
                scan_next            = '0;
                ram_raddr            = '0;
                // Empty table: store the first flow at once
                if (cls_comb == CLS_TCP && flows_reg == '0)
                begin
                    ram_we            = 1'b1;
                    ram_wdata         = key_comb;
                    res_next.new_flow = 1'b1;
                    flows_next        = flows_reg + FLOW_CNT_BITS'(1);
                end
            end
            ST_SEARCH:
            begin
                // One entry per cycle; read the next while comparing this one
                ram_raddr = scan_reg + FLOW_ID_BITS'(1);
                priority if (hit)
                begin
                    res_next.flow_id = scan_reg;
                end
                else if (scan_done)
                begin
                    if (room)
                    begin
                        ram_we            = 1'b1;
                        res_next.flow_id  = flows_reg[FLOW_ID_BITS-1:0];
                        res_next.new_flow = 1'b1;
                        flows_next        = flows_reg + FLOW_CNT_BITS'(1);
                    end
                    else
                    begin
                        res_next.table_full = 1'b1;
                    end
                end
                else
                begin
                    scan_next = scan_reg + FLOW_ID_BITS'(1);
                end
            end
            ST_EMIT:
            begin
                // Once the output is free, load the output word and clear the frame registers
                if (out_free)
                begin
                    out_next        = res_reg;
                    out_valid_next  = 1'b1;
                    byte_index_next = '0;
                    hlen_next       = '0;
                    proto_next      = '0;
                    saddr_next      = '0;
                    daddr_next      = '0;
                    ports_next      = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign result_out.valid       = out_valid_reg;
    assign result_out.frame_class = out_reg.frame_class;
    assign result_out.flow_id     = out_reg.flow_id;
    assign result_out.new_flow    = out_reg.new_flow;
    assign result_out.table_full  = out_reg.table_full;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_en_reg   <= 1'b0;
            filter_addr_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FILTER_ENABLE: filter_en_reg   <= cfg_data[0];
                CFG_FILTER_ADDR:   filter_addr_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Control and frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CAPTURE;
            byte_index_reg <= '0;
            hlen_reg       <= '0;
            proto_reg      <= '0;
            saddr_reg      <= '0;
            daddr_reg      <= '0;
            ports_reg      <= '0;
            flows_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            byte_index_reg <= byte_index_next;
            hlen_reg       <= hlen_next;
            proto_reg      <= proto_next;
            saddr_reg      <= saddr_next;
            daddr_reg      <= daddr_next;
            ports_reg      <= ports_next;
            flows_reg      <= flows_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        scan_reg <= scan_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

endmodule
